### rtl/weighted_tile_state_selector_core_defines.svh
// Assertion macros shared by the weighted tile state selector RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef WEIGHTED_TILE_STATE_SELECTOR_CORE_DEFINES_SVH
`define WEIGHTED_TILE_STATE_SELECTOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define WTSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define WTSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WTSS_ASSERT(label, prop, msg)
`define WTSS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### rtl/wtss_pkg.sv
// Package of the weighted tile state selector: item types, codes and defaults.
// Used by the controller, the datapath and the top level.
package wtss_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned WeightBitsDef = 16;

  localparam int unsigned ID_W     = 6;
  localparam int unsigned IN_W_W   = 16;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned TOTAL_W  = 20;
  localparam int unsigned OUT_CNT_W = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_LOAD      = 2'd0,
    KIND_CONSTRAIN = 2'd1,
    KIND_COLLAPSE  = 2'd2,
    KIND_NOP       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_DRAW = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic               first_entry;
    logic               last_entry;
    logic [ID_W-1:0]    entry_id;
    logic [IN_W_W-1:0]  entry_weight;
    logic [MASK_W-1:0]  allowed_mask;
    logic [TOTAL_W-1:0] draw;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 collapsed;
    logic [ID_W-1:0]      chosen_id;
    logic [TOTAL_W-1:0]   weight_total;
    logic [OUT_CNT_W-1:0] entry_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic walk;
    logic fin;
  } wtss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  draw_bad;
    logic  walk_done;
    logic  out_free;
  } wtss_sts_t;

endpackage

### rtl/weighted_tile_state_selector_core.sv
// Top level of the weighted tile state selector (roulette-wheel pick).
// Depends on wtss_pkg, wtss_ctrl and wtss_dp.
//
// The block keeps an ordered list of candidate states, each an id with a
// weight, plus the running weight total. Items arrive on the in_* channel
// with valid and ready, and every item returns exactly one result item on
// the out_* channel. A load item appends an entry, a constrain item drops
// entries whose id is not in the allowed mask, and a collapse item picks the
// first entry whose weight covers what is left of the draw.
// The block works on one item at a time. A load, a no-op or a bad draw goes
// from capture through the execute state to the finish state. Constrain and
// collapse walk the stored entries through the registered read port, one per
// cycle. The controller returns to idle, ready for the next item, in the same
// cycle that the result enters the output register and out_valid_o rises.
// While a result waits in the output register the next item is still taken;
// if the receiver stalls with out_ready_i low, the next finished result holds
// in the controller until the register frees.
// Reset empties the list, clears the total and the choice, and drops any
// pending result; the entry memory itself is not cleared.

module weighted_tile_state_selector_core #(
  parameter int unsigned MAX_ENTRIES = wtss_pkg::MaxEntriesDef,
  parameter int unsigned WEIGHT_BITS = wtss_pkg::WeightBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wtss_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wtss_pkg::out_item_t out_item_o
);
  import wtss_pkg::*;

  // Command and status groups between the controller and the datapath.
  wtss_cmd_t cmd;
  wtss_sts_t sts;

  // The controller sequences each item: capture, execute, walk the entries
  // when the kind needs it, then hand the result to the output register.
  wtss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the entry memory, the list state and the result.
  wtss_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/wtss_ctrl.sv
// Controller state machine of the weighted tile state selector.
// Depends on wtss_pkg and the assertion macro header.
`include "weighted_tile_state_selector_core_defines.svh"

module wtss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wtss_pkg::wtss_sts_t sts_i,
  output wtss_pkg::wtss_cmd_t cmd_o
);
  import wtss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.kind == KIND_CONSTRAIN ||
            (sts_i.kind == KIND_COLLAPSE && !sts_i.draw_bad)) begin
          state_d = S_WALK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `WTSS_ASSERT(a_walk_kind, (state_q == S_WALK) |-> (sts_i.kind == KIND_CONSTRAIN || sts_i.kind == KIND_COLLAPSE), "walk started for an item kind that has no walk")
  `WTSS_ASSERT(a_walk_draw, (state_q == S_WALK && sts_i.kind == KIND_COLLAPSE) |-> !sts_i.draw_bad, "collapse walk started with an out-of-range draw")

endmodule

### rtl/wtss_dp.sv
// Datapath of the weighted tile state selector: entry memory, list state,
// walk counters and the result register. Depends on wtss_pkg and the macro header.
`include "weighted_tile_state_selector_core_defines.svh"

module wtss_dp #(
  parameter int unsigned MAX_ENTRIES = wtss_pkg::MaxEntriesDef,
  parameter int unsigned WEIGHT_BITS = wtss_pkg::WeightBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wtss_pkg::in_item_t  in_item_i,
  input  wtss_pkg::wtss_cmd_t cmd_i,
  output wtss_pkg::wtss_sts_t sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output wtss_pkg::out_item_t out_item_o
);
  import wtss_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = ((WEIGHT_BITS > TOTAL_W) ? WEIGHT_BITS : TOTAL_W) + 1;

  // Entry memory: one write and one registered read per cycle.
  logic [ID_W-1:0]        id_mem [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0] w_mem  [MAX_ENTRIES];
  logic [ID_W-1:0]        rd_id_q;
  logic [WEIGHT_BITS-1:0] rd_w_q;
  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [ID_W-1:0]        wr_id;
  logic [WEIGHT_BITS-1:0] wr_w;

  in_item_t item_q;

  logic [CW-1:0]      count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [ID_W-1:0]    chosen_q, chosen_d;
  logic               collapsed_q, collapsed_d;
  status_e            status_q, status_d;
  logic [CW-1:0]      issue_q, issue_d;
  logic [CW-1:0]      wp_q, wp_d;
  logic [TOTAL_W-1:0] left_q, left_d;
  logic               rd_pend_q, rd_pend_d;
  logic               hit_q, hit_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  kind_e                  kind;
  logic [WEIGHT_BITS-1:0] in_w;
  logic [CW-1:0]          ld_cnt, ld_cnt_new;
  logic [TOTAL_W-1:0]     ld_tot;
  logic [SUM_W-1:0]       ld_sum;
  logic [SUM_W-1:0]       eval_w, tot_ext, left_ext;
  logic                   draw_bad;

  assign kind     = kind_e'(item_q.kind);
  assign in_w     = WEIGHT_BITS'(item_q.entry_weight);
  assign draw_bad = (item_q.draw == '0) || (item_q.draw > total_q);
  assign ld_cnt   = item_q.first_entry ? '0 : count_q;
  assign ld_tot   = item_q.first_entry ? '0 : total_q;
  assign ld_sum   = SUM_W'(ld_tot) + SUM_W'(in_w);
  assign eval_w   = SUM_W'(rd_w_q);
  assign tot_ext  = SUM_W'(total_q);
  assign left_ext = SUM_W'(left_q);

  always_comb begin
    count_d     = count_q;
    total_d     = total_q;
    chosen_d    = chosen_q;
    collapsed_d = collapsed_q;
    status_d    = status_q;
    issue_d     = issue_q;
    wp_d        = wp_q;
    left_d      = left_q;
    rd_pend_d   = rd_pend_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_id       = '0;
    wr_w        = '0;
    rd_en       = 1'b0;
    rd_addr     = issue_q[AW-1:0];
    ld_cnt_new  = ld_cnt;

    if (cmd_i.exec) begin
      status_d  = ST_OK;
      issue_d   = '0;
      wp_d      = '0;
      left_d    = item_q.draw;
      rd_pend_d = 1'b0;
      hit_d     = 1'b0;
      case (kind)
        KIND_LOAD: begin
          if (item_q.first_entry) begin
            collapsed_d = 1'b0;
            chosen_d    = '0;
          end
          if (ld_cnt < CW'(MAX_ENTRIES)) begin
            wr_en      = 1'b1;
            wr_addr    = ld_cnt[AW-1:0];
            wr_id      = item_q.entry_id;
            wr_w       = in_w;
            ld_cnt_new = ld_cnt + CW'(1);
            total_d    = (ld_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : ld_sum[TOTAL_W-1:0];
          end else begin
            total_d  = ld_tot;
            status_d = ST_FULL;
          end
          count_d = ld_cnt_new;
          if (item_q.last_entry) begin
            // A single entry after the append can only be the one just loaded.
            if (ld_cnt_new == '0) begin
              status_d    = ST_EMPTY;
              collapsed_d = 1'b0;
              chosen_d    = '0;
            end else if (ld_cnt_new == CW'(1)) begin
              collapsed_d = 1'b1;
              chosen_d    = item_q.entry_id;
            end else begin
              collapsed_d = 1'b0;
              chosen_d    = '0;
            end
          end
        end
        KIND_COLLAPSE: begin
          if (draw_bad) begin
            status_d = ST_BAD_DRAW;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.walk) begin
      // Evaluate the entry read in the previous cycle.
      if (rd_pend_q && !hit_q) begin
        if (kind == KIND_CONSTRAIN) begin
          if (item_q.allowed_mask[rd_id_q]) begin
            wr_en   = 1'b1;
            wr_addr = wp_q[AW-1:0];
            wr_id   = rd_id_q;
            wr_w    = rd_w_q;
            wp_d    = wp_q + CW'(1);
          end else begin
            total_d = (eval_w > tot_ext) ? '0 : TOTAL_W'(tot_ext - eval_w);
          end
        end else begin
          if (left_ext <= eval_w) begin
            chosen_d    = rd_id_q;
            collapsed_d = 1'b1;
            hit_d       = 1'b1;
          end else begin
            left_d = TOTAL_W'(left_ext - eval_w);
          end
        end
      end
      // Issue the next read.
      if (!hit_q && issue_q != count_q) begin
        rd_en     = 1'b1;
        issue_d   = issue_q + CW'(1);
        rd_pend_d = 1'b1;
      end else begin
        rd_pend_d = 1'b0;
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.fin) begin
      if (kind == KIND_CONSTRAIN) begin
        count_d = wp_q;
      end
      out_valid_d             = 1'b1;
      out_item_d.status       = status_q;
      out_item_d.collapsed    = collapsed_q;
      out_item_d.chosen_id    = collapsed_q ? chosen_q : '0;
      out_item_d.weight_total = total_q;
      out_item_d.entry_count  = OUT_CNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_addr] <= wr_id;
      w_mem[wr_addr]  <= wr_w;
    end
    if (rd_en) begin
      rd_id_q <= id_mem[rd_addr];
      rd_w_q  <= w_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    left_q     <= left_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      chosen_q    <= '0;
      collapsed_q <= 1'b0;
      status_q    <= ST_OK;
      issue_q     <= '0;
      wp_q        <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      chosen_q    <= chosen_d;
      collapsed_q <= collapsed_d;
      status_q    <= status_d;
      issue_q     <= issue_d;
      wp_q        <= wp_d;
      rd_pend_q   <= rd_pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.kind      = kind;
  assign sts_o.draw_bad  = draw_bad;
  assign sts_o.walk_done = hit_q || (issue_q == count_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;

  `WTSS_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES), "entry count above list capacity")
  `WTSS_ASSERT(a_wp_behind, cmd_i.walk |-> (wp_q <= issue_q), "compaction write pointer passed the read pointer")
  `WTSS_ASSERT(a_hit_collapsed, hit_q |-> collapsed_q, "collapse hit without the collapsed flag")

endmodule
